// ===== rtl/lpbd_pkg.sv =====
// Package for the LRU page buffer directory.
// Holds field widths, command/result codes, FSM state and control structs.
// No dependencies.
package lpbd_pkg;

  localparam int PGW  = 31;  // page number width
  localparam int FRW  = 6;   // frame field width
  localparam int CNTW = 32;  // statistics counter width
  localparam int PINW = 16;  // pin count width
  localparam int RKW  = 6;   // recency rank width
  localparam int FCW  = 7;   // frame count width

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_FIX       = 3'd0;
  localparam cmd_t CMD_UNFIX     = 3'd1;
  localparam cmd_t CMD_SET_DIRTY = 3'd2;
  localparam cmd_t CMD_CLR_DIRTY = 3'd3;
  localparam cmd_t CMD_FLUSH     = 3'd4;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_GRANT      = 3'd0;
  localparam kind_t KIND_WRITE_BACK = 3'd1;
  localparam kind_t KIND_FETCH      = 3'd2;
  localparam kind_t KIND_UNFIX      = 3'd3;
  localparam kind_t KIND_DIRTY      = 3'd4;
  localparam kind_t KIND_FLUSH_NONE = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t STS_OK        = 2'd0;
  localparam status_t STS_NOT_FOUND = 2'd1;
  localparam status_t STS_PIN_ZERO  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_FIX_DEC, S_TOUCH, S_TOUCH_W,
    S_EM_WB, S_EM_RF, S_EM_GR, S_UNFIX_DEC, S_EM_UNFIX,
    S_DIRTY, S_EM_DIRTY, S_FL_START, S_FL_SCAN, S_FL_EMIT
  } lpbd_state_t;

  typedef enum logic [2:0] {
    EM_EVICT_WB, EM_FETCH, EM_GRANT, EM_UNFIX, EM_DIRTY, EM_FLUSH_WB, EM_FLUSH_NONE
  } emit_sel_t;

  typedef enum logic {SW_SEARCH, SW_TOUCH} sweep_mode_t;

  typedef struct packed {
    logic        ld;
    logic        sw_go;
    sweep_mode_t sw_mode;
    logic        fix_dec;
    logic        unfix_dec;
    logic        dirty_op;
    logic        fl_clr;
    logic        fl_inc;
    logic        fl_rd;
    logic        emit;
    emit_sel_t   em_sel;
    logic        em_last;
  } lpbd_cmd_t;

  typedef struct packed {
    logic sw_busy;
    logic found;
    logic evict_wb;
    logic wr;
    logic is_fix;
    logic out_free;
    logic fl_any;
    logic fl_dirty;
    logic fl_more;
  } lpbd_stat_t;

endpackage

// ===== rtl/lpbd_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on lpbd_pkg.
interface lpbd_in_if;
  logic                  valid;
  logic                  ready;
  lpbd_pkg::cmd_t        command;
  logic [lpbd_pkg::PGW-1:0] page;
  logic                  write_intent;
  logic [lpbd_pkg::FRW-1:0] frame_sel;
  modport source (output valid, command, page, write_intent, frame_sel, input ready);
  modport sink   (input valid, command, page, write_intent, frame_sel, output ready);
endinterface

interface lpbd_out_if;
  logic                      valid;
  logic                      ready;
  lpbd_pkg::kind_t           kind;
  logic [lpbd_pkg::FRW-1:0]  frame;
  logic [lpbd_pkg::PGW-1:0]  page_out;
  logic                      hit;
  lpbd_pkg::status_t         status;
  logic [lpbd_pkg::CNTW-1:0] ops_seen;
  logic [lpbd_pkg::CNTW-1:0] hits_seen;
  logic                      last;
  modport source (output valid, kind, frame, page_out, hit, status, ops_seen, hits_seen,
                  last, input ready);
  modport sink   (input valid, kind, frame, page_out, hit, status, ops_seen, hits_seen,
                  last, output ready);
endinterface

// ===== rtl/lpbd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lpbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/lpbd_ctrl.sv =====
// Controller FSM: sequences search, decision, recency sweep, flush scan and results.
// Depends on lpbd_pkg.
module lpbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lpbd_pkg::cmd_t      in_command,
  output logic                in_ready,
  input  lpbd_pkg::lpbd_stat_t stat,
  output lpbd_pkg::lpbd_cmd_t  cmd
);
  import lpbd_pkg::*;

  lpbd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld = 1'b1;
          unique case (in_command) inside
            CMD_FIX, CMD_UNFIX:           state_nxt = S_SRCH;
            CMD_SET_DIRTY, CMD_CLR_DIRTY: state_nxt = S_DIRTY;
            CMD_FLUSH:                    state_nxt = S_FL_START;
            default:                      state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRCH: begin
        cmd.sw_go   = 1'b1;
        cmd.sw_mode = SW_SEARCH;
        state_nxt   = S_SRCH_W;
      end
      S_SRCH_W: begin
        if (!stat.sw_busy) state_nxt = stat.is_fix ? S_FIX_DEC : S_UNFIX_DEC;
      end
      S_FIX_DEC: begin
        cmd.fix_dec = 1'b1;
        state_nxt   = S_TOUCH;
      end
      S_TOUCH: begin
        cmd.sw_go   = 1'b1;
        cmd.sw_mode = SW_TOUCH;
        state_nxt   = S_TOUCH_W;
      end
      S_TOUCH_W: begin
        if (!stat.sw_busy) begin
          if (stat.found)         state_nxt = S_EM_GR;
          else if (stat.evict_wb) state_nxt = S_EM_WB;
          else if (!stat.wr)      state_nxt = S_EM_RF;
          else                    state_nxt = S_EM_GR;
        end
      end
      S_EM_WB: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.em_sel = EM_EVICT_WB;
          state_nxt  = stat.wr ? S_EM_GR : S_EM_RF;
        end
      end
      S_EM_RF: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.em_sel = EM_FETCH;
          state_nxt  = S_EM_GR;
        end
      end
      S_EM_GR: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.em_sel  = EM_GRANT;
          cmd.em_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_UNFIX_DEC: begin
        cmd.unfix_dec = 1'b1;
        state_nxt     = S_EM_UNFIX;
      end
      S_EM_UNFIX: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.em_sel  = EM_UNFIX;
          cmd.em_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DIRTY: begin
        cmd.dirty_op = 1'b1;
        state_nxt    = S_EM_DIRTY;
      end
      S_EM_DIRTY: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.em_sel  = EM_DIRTY;
          cmd.em_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_FL_START: begin
        if (!stat.fl_any) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.em_sel  = EM_FLUSH_NONE;
            cmd.em_last = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.fl_clr = 1'b1;
          state_nxt  = S_FL_SCAN;
        end
      end
      S_FL_SCAN: begin
        if (stat.fl_dirty) begin
          cmd.fl_rd = 1'b1;
          state_nxt = S_FL_EMIT;
        end else begin
          cmd.fl_inc = 1'b1;
        end
      end
      S_FL_EMIT: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.em_sel  = EM_FLUSH_WB;
          cmd.em_last = !stat.fl_more;
          cmd.fl_inc  = 1'b1;
          state_nxt   = stat.fl_more ? S_FL_SCAN : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/lpbd_dp.sv =====
// Datapath: frame tables, sweep engine, counters and result register.
// Depends on lpbd_pkg and lpbd_ram.
module lpbd_dp #(
  parameter int FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpbd_pkg::lpbd_cmd_t           cmd,
  output lpbd_pkg::lpbd_stat_t          stat,
  input  lpbd_pkg::cmd_t                in_command,
  input  logic [lpbd_pkg::PGW-1:0]      in_page,
  input  logic                          in_write_intent,
  input  logic [lpbd_pkg::FRW-1:0]      in_frame_sel,
  input  logic                          out_ready,
  output logic                          out_valid,
  output lpbd_pkg::kind_t               out_kind,
  output logic [lpbd_pkg::FRW-1:0]      out_frame,
  output logic [lpbd_pkg::PGW-1:0]      out_page_out,
  output logic                          out_hit,
  output lpbd_pkg::status_t             out_status,
  output logic [lpbd_pkg::CNTW-1:0]     out_ops_seen,
  output logic [lpbd_pkg::CNTW-1:0]     out_hits_seen,
  output logic                          out_last
);
  import lpbd_pkg::*;

  localparam int AW = $clog2(FRAMES);
  localparam logic [FCW-1:0] FRAMES_C  = FCW'(FRAMES);
  localparam logic [FCW-1:0] LAST_RANK = FCW'(FRAMES - 1);

  // latched request
  cmd_t           cmd_r;
  logic [PGW-1:0] page_r;
  logic           wr_r;
  logic [FRW-1:0] fsel_r;

  // control state
  logic [FCW-1:0]    free_r;
  logic [CNTW-1:0]   fix_total_r, hit_total_r;
  logic [FRAMES-1:0] dirty_r, pin_vld_r;
  logic              sw_act_r, s1_vld_r;
  sweep_mode_t       sw_mode_r;
  logic [FCW-1:0]    idx_r;
  logic              out_valid_r;

  // sweep results and decision registers
  logic [AW-1:0]   s1_idx_r;
  logic            found_r, vfound_r, wb_r, dv_r;
  logic [AW-1:0]   hf_r, vic_r, tgt_r, fr_r;
  logic [RKW-1:0]  hrank_r;
  logic [PINW-1:0] hpin_r;
  logic [PGW-1:0]  vpage_r;
  logic [FCW-1:0]  trank_r, tn_r;

  // result payload
  kind_t           o_kind_r;
  logic [FRW-1:0]  o_frame_r;
  logic [PGW-1:0]  o_page_r;
  logic            o_hit_r, o_last_r;
  status_t         o_status_r;
  logic [CNTW-1:0] o_ops_r, o_hits_r;

  // RAM ports
  logic [PGW-1:0]  pg_rdata;
  logic [RKW-1:0]  rk_rdata, rk_wdata;
  logic [PINW-1:0] pn_rdata, pn_wdata;
  logic            pg_we, pg_re, rk_we, pn_we, sw_re;
  logic [AW-1:0]   pg_raddr, pn_waddr, f_new;

  logic [FCW-1:0]  used, sw_n;
  logic [PINW-1:0] pin_eff;
  logic            dvalid, fl_more;
  logic [FCW-1:0]  rk_ext;

  assign used    = FRAMES_C - free_r;
  assign sw_n    = (sw_mode_r == SW_SEARCH) ? used : tn_r;
  assign sw_re   = sw_act_r && (idx_r < sw_n);
  assign pin_eff = pin_vld_r[s1_idx_r] ? pn_rdata : '0;
  assign dvalid  = FCW'(fsel_r) < used;
  assign rk_ext  = FCW'(rk_rdata);

  // frame chosen by the fix decision
  always_comb begin
    if (found_r)          f_new = hf_r;
    else if (free_r != 0) f_new = used[AW-1:0];
    else                  f_new = vic_r;
  end

  always_comb begin
    fl_more = 1'b0;
    for (int j = 0; j < FRAMES; j++)
      if (dirty_r[j] && (FCW'(j) > idx_r)) fl_more = 1'b1;
  end

  // page table
  assign pg_we    = cmd.fix_dec && !found_r;
  assign pg_re    = sw_re || (cmd.dirty_op && dvalid) || cmd.fl_rd;
  assign pg_raddr = cmd.dirty_op ? fsel_r[AW-1:0] : idx_r[AW-1:0];

  // rank table, written during the recency sweep
  assign rk_we    = s1_vld_r && (sw_mode_r == SW_TOUCH) &&
                    ((s1_idx_r == tgt_r) || (rk_ext < trank_r));
  assign rk_wdata = (s1_idx_r == tgt_r) ? '0 : rk_rdata + RKW'(1);

  // pin table
  always_comb begin
    pn_we    = cmd.fix_dec || (cmd.unfix_dec && found_r && (hpin_r != '0));
    pn_waddr = cmd.fix_dec ? f_new : hf_r;
    if (cmd.fix_dec) begin
      if (!found_r)           pn_wdata = PINW'(1);
      else if (hpin_r == '1)  pn_wdata = hpin_r;
      else                    pn_wdata = hpin_r + PINW'(1);
    end else begin
      pn_wdata = hpin_r - PINW'(1);
    end
  end

  lpbd_ram #(.WIDTH(PGW), .DEPTH(FRAMES)) u_pg_ram (
    .clk(clk), .we(pg_we), .waddr(f_new), .wdata(page_r),
    .re(pg_re), .raddr(pg_raddr), .rdata(pg_rdata)
  );

  lpbd_ram #(.WIDTH(RKW), .DEPTH(FRAMES)) u_rk_ram (
    .clk(clk), .we(rk_we), .waddr(s1_idx_r), .wdata(rk_wdata),
    .re(sw_re), .raddr(idx_r[AW-1:0]), .rdata(rk_rdata)
  );

  lpbd_ram #(.WIDTH(PINW), .DEPTH(FRAMES)) u_pn_ram (
    .clk(clk), .we(pn_we), .waddr(pn_waddr), .wdata(pn_wdata),
    .re(sw_re), .raddr(idx_r[AW-1:0]), .rdata(pn_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= FRAMES_C;
      fix_total_r <= '0;
      hit_total_r <= '0;
      dirty_r     <= '0;
      pin_vld_r   <= '0;
      sw_act_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld && (in_command == CMD_FIX)) fix_total_r <= fix_total_r + CNTW'(1);

      if (cmd.sw_go) begin
        sw_act_r <= 1'b1;
        s1_vld_r <= 1'b0;
      end else if (sw_act_r) begin
        s1_vld_r <= sw_re;
        if (!sw_re && !s1_vld_r) sw_act_r <= 1'b0;
      end

      if (pn_we) pin_vld_r[pn_waddr] <= 1'b1;

      if (cmd.fix_dec) begin
        if (found_r) begin
          hit_total_r <= hit_total_r + CNTW'(1);
          if (wr_r) dirty_r[hf_r] <= 1'b1;
        end else begin
          dirty_r[f_new] <= wr_r;
          if (free_r != 0) free_r <= free_r - FCW'(1);
        end
      end
      if (cmd.dirty_op && dvalid) dirty_r[fsel_r[AW-1:0]] <= (cmd_r == CMD_SET_DIRTY);
      if (cmd.emit && (cmd.em_sel == EM_FLUSH_WB)) dirty_r[idx_r[AW-1:0]] <= 1'b0;

      if (cmd.emit)         out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      cmd_r  <= in_command;
      page_r <= in_page;
      wr_r   <= in_write_intent;
      fsel_r <= in_frame_sel;
    end

    if (cmd.sw_go) begin
      idx_r     <= '0;
      sw_mode_r <= cmd.sw_mode;
      if (cmd.sw_mode == SW_SEARCH) begin
        found_r  <= 1'b0;
        vfound_r <= 1'b0;
      end
    end else if (sw_re) begin
      idx_r    <= idx_r + FCW'(1);
      s1_idx_r <= idx_r[AW-1:0];
    end else if (cmd.fl_clr) begin
      idx_r <= '0;
    end else if (cmd.fl_inc) begin
      idx_r <= idx_r + FCW'(1);
    end

    // search compare on the registered table read
    if (s1_vld_r && (sw_mode_r == SW_SEARCH)) begin
      if (!found_r && (pg_rdata == page_r)) begin
        found_r <= 1'b1;
        hf_r    <= s1_idx_r;
        hrank_r <= rk_rdata;
        hpin_r  <= pin_eff;
      end
      if (!vfound_r && (rk_ext == LAST_RANK)) begin
        vfound_r <= 1'b1;
        vic_r    <= s1_idx_r;
        vpage_r  <= pg_rdata;
      end
    end

    if (cmd.fix_dec) begin
      fr_r  <= f_new;
      tgt_r <= f_new;
      wb_r  <= !found_r && (free_r == 0) && dirty_r[vic_r];
      if (found_r) begin
        trank_r <= FCW'(hrank_r);
        tn_r    <= used;
      end else if (free_r != 0) begin
        trank_r <= used;
        tn_r    <= used + FCW'(1);
      end else begin
        trank_r <= LAST_RANK;
        tn_r    <= FRAMES_C;
      end
    end

    if (cmd.dirty_op) dv_r <= dvalid;

    if (cmd.emit) begin
      o_last_r   <= cmd.em_last;
      o_ops_r    <= fix_total_r;
      o_hits_r   <= hit_total_r;
      o_hit_r    <= 1'b0;
      o_status_r <= STS_OK;
      case (cmd.em_sel)
        EM_EVICT_WB: begin
          o_kind_r  <= KIND_WRITE_BACK;
          o_frame_r <= FRW'(vic_r);
          o_page_r  <= vpage_r;
        end
        EM_FETCH: begin
          o_kind_r  <= KIND_FETCH;
          o_frame_r <= FRW'(fr_r);
          o_page_r  <= page_r;
        end
        EM_GRANT: begin
          o_kind_r  <= KIND_GRANT;
          o_frame_r <= FRW'(fr_r);
          o_page_r  <= page_r;
          o_hit_r   <= found_r;
        end
        EM_UNFIX: begin
          o_kind_r <= KIND_UNFIX;
          o_page_r <= page_r;
          if (!found_r) begin
            o_frame_r  <= '0;
            o_status_r <= STS_NOT_FOUND;
          end else begin
            o_frame_r  <= FRW'(hf_r);
            o_status_r <= (hpin_r == '0) ? STS_PIN_ZERO : STS_OK;
          end
        end
        EM_DIRTY: begin
          o_kind_r   <= KIND_DIRTY;
          o_frame_r  <= fsel_r;
          o_page_r   <= dv_r ? pg_rdata : '0;
          o_status_r <= dv_r ? STS_OK : STS_NOT_FOUND;
        end
        EM_FLUSH_WB: begin
          o_kind_r  <= KIND_WRITE_BACK;
          o_frame_r <= FRW'(idx_r[AW-1:0]);
          o_page_r  <= pg_rdata;
        end
        default: begin
          o_kind_r  <= KIND_FLUSH_NONE;
          o_frame_r <= '0;
          o_page_r  <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat          = '0;
    stat.sw_busy  = sw_act_r;
    stat.found    = found_r;
    stat.evict_wb = wb_r;
    stat.wr       = wr_r;
    stat.is_fix   = (cmd_r == CMD_FIX);
    stat.out_free = !out_valid_r || out_ready;
    stat.fl_any   = |dirty_r;
    stat.fl_dirty = (idx_r < used) && dirty_r[idx_r[AW-1:0]];
    stat.fl_more  = fl_more;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = o_kind_r;
  assign out_frame     = o_frame_r;
  assign out_page_out  = o_page_r;
  assign out_hit       = o_hit_r;
  assign out_status    = o_status_r;
  assign out_ops_seen  = o_ops_r;
  assign out_hits_seen = o_hits_r;
  assign out_last      = o_last_r;
endmodule

// ===== rtl/lru_page_buffer_directory_unit.sv =====
// Top level of the LRU page buffer directory.
// Depends on lpbd_pkg, lpbd_if, lpbd_ctrl, lpbd_dp (and lpbd_ram below it).
//
// Usage:
//  - in_ch carries one request item per valid/ready handshake: fix, unfix,
//    set dirty, clear dirty or flush. out_ch carries result items; the final
//    result of a request has last set. Unknown commands produce no result.
//  - One request is worked at a time; in_ch.ready is high only when idle.
//  - Fix: accept step, one pipelined search pass over the frames in use
//    (with its start step, tables read one entry a cycle), one decision step,
//    one recency pass over up to FRAMES entries, then one to three results.
//  - Unfix: search pass, pin update, result. Set/clear dirty: update, result.
//  - Flush: a start step, then a scan of the frames up to the last dirty one,
//    with one write-back result per dirty frame.
//  - Results sit in a single output register; a new request is taken while
//    the final result still waits. A stalled receiver holds the block in its
//    emit step; nothing is dropped.
//  - Synchronous active-low reset empties the directory (all frames free,
//    no dirty marks, pins zero, counters zero). No clearing pass is needed:
//    pin counts use per-frame valid flops, other tables are read only after
//    being written.
module lru_page_buffer_directory_unit #(
  parameter int FRAMES = 64
) (
  input logic       clk,
  input logic       rst_n,
  lpbd_in_if.sink   in_ch,
  lpbd_out_if.source out_ch
);
  import lpbd_pkg::*;

  lpbd_cmd_t  cmd;
  lpbd_stat_t stat;

  lpbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lpbd_dp #(.FRAMES(FRAMES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_page         (in_ch.page),
    .in_write_intent (in_ch.write_intent),
    .in_frame_sel    (in_ch.frame_sel),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_frame       (out_ch.frame),
    .out_page_out    (out_ch.page_out),
    .out_hit         (out_ch.hit),
    .out_status      (out_ch.status),
    .out_ops_seen    (out_ch.ops_seen),
    .out_hits_seen   (out_ch.hits_seen),
    .out_last        (out_ch.last)
  );
endmodule

// ===== verif/lpbd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LRU page buffer directory: watches both channels, predicts
// result items with a directory model of its own and compares them in order.
// Depends on lpbd_pkg and lpbd_if.
module lpbd_checker #(
  parameter int FRAMES = 64
) (
  input logic       clk,
  input logic       rst_n,
  lpbd_in_if.sink   mon_in,
  lpbd_out_if.sink  mon_out,
  output int        fail_count,
  output int        pending_results
);
  import lpbd_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic [FRW-1:0]       frame;
    logic [PGW-1:0]       page_out;
    logic                 hit;
    status_t              status;
    logic [CNTW-1:0]      ops_seen;
    logic [CNTW-1:0]      hits_seen;
    logic                 last;
  } dir_result_t;

  dir_result_t          expected_results[$];
  logic [PGW-1:0]       frame_page[64];
  logic                 frame_dirty[64];
  logic [PINW-1:0]      frame_pins[64];
  logic [RKW-1:0]       frame_rank[64];
  int                   unused_frames;
  logic [CNTW-1:0]      fix_count, hit_tally;
  int                   batch_n;

  assign pending_results = expected_results.size();

  function automatic int frames_in_use();
    return FRAMES - unused_frames;
  endfunction

  task automatic push_result(kind_t k, int f, logic [PGW-1:0] p, logic h, status_t s);
    dir_result_t r;
    r.kind = k; r.frame = f[FRW-1:0]; r.page_out = p; r.hit = h; r.status = s;
    r.ops_seen = fix_count; r.hits_seen = hit_tally; r.last = 1'b0;
    expected_results.push_back(r);
    batch_n++;
  endtask

  // move frame f to rank 0, aging younger frames among the first n
  task automatic promote(int f, int n);
    logic [RKW-1:0] r;
    r = frame_rank[f];
    for (int i = 0; i < n && i < 64; i++)
      if (i != f && frame_rank[i] < r) frame_rank[i]++;
    frame_rank[f] = '0;
  endtask

  task automatic predict_request(cmd_t cmd, logic [PGW-1:0] pg, logic wr,
                                 logic [FRW-1:0] fsel);
    int used, f;
    bit found;
    used = frames_in_use();
    f = 0;
    found = 0;
    batch_n = 0;
    case (cmd)
      CMD_FIX: begin
        fix_count++;
        for (int i = 0; i < used; i++)
          if (!found && frame_page[i] == pg) begin
            f = i; found = 1;
          end
        if (found) begin
          hit_tally++;
          promote(f, used);
          if (frame_pins[f] != '1) frame_pins[f]++;
          if (wr) frame_dirty[f] = 1'b1;
          push_result(KIND_GRANT, f, pg, 1'b1, STS_OK);
        end else begin
          if (unused_frames > 0) begin
            f = used;
            unused_frames--;
            frame_rank[f] = used[RKW-1:0];
            promote(f, used + 1);
          end else begin
            for (int i = FRAMES - 1; i >= 0; i--)
              if (frame_rank[i] == FRAMES - 1) f = i;
            if (frame_dirty[f])
              push_result(KIND_WRITE_BACK, f, frame_page[f], 1'b0, STS_OK);
            promote(f, FRAMES);
          end
          frame_page[f] = pg;
          frame_dirty[f] = wr;
          frame_pins[f] = PINW'(1);
          if (!wr) push_result(KIND_FETCH, f, pg, 1'b0, STS_OK);
          push_result(KIND_GRANT, f, pg, 1'b0, STS_OK);
        end
      end
      CMD_UNFIX: begin
        for (int i = 0; i < used; i++)
          if (!found && frame_page[i] == pg) begin
            f = i; found = 1;
          end
        if (!found) push_result(KIND_UNFIX, 0, pg, 1'b0, STS_NOT_FOUND);
        else if (frame_pins[f] == 0) push_result(KIND_UNFIX, f, pg, 1'b0, STS_PIN_ZERO);
        else begin
          frame_pins[f]--;
          push_result(KIND_UNFIX, f, pg, 1'b0, STS_OK);
        end
      end
      CMD_SET_DIRTY, CMD_CLR_DIRTY: begin
        if (fsel >= used) push_result(KIND_DIRTY, fsel, '0, 1'b0, STS_NOT_FOUND);
        else begin
          frame_dirty[fsel] = (cmd == CMD_SET_DIRTY);
          push_result(KIND_DIRTY, fsel, frame_page[fsel], 1'b0, STS_OK);
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < used; i++)
          if (frame_dirty[i]) begin
            push_result(KIND_WRITE_BACK, i, frame_page[i], 1'b0, STS_OK);
            frame_dirty[i] = 1'b0;
            found = 1;
          end
        if (!found) push_result(KIND_FLUSH_NONE, 0, '0, 1'b0, STS_OK);
      end
      default: ;
    endcase
    if (batch_n > 0) expected_results[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    dir_result_t got, exp_r;
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < 64; i++) begin
        frame_page[i] = '0; frame_dirty[i] = 1'b0; frame_pins[i] = '0; frame_rank[i] = '0;
      end
      unused_frames = FRAMES;
      fix_count = '0;
      hit_tally = '0;
      fail_count = 0;
    end else begin
      if (mon_in.valid && mon_in.ready)
        predict_request(mon_in.command, mon_in.page, mon_in.write_intent, mon_in.frame_sel);
      if (mon_out.valid && mon_out.ready) begin
        got.kind = mon_out.kind; got.frame = mon_out.frame; got.page_out = mon_out.page_out;
        got.hit = mon_out.hit; got.status = mon_out.status; got.ops_seen = mon_out.ops_seen;
        got.hits_seen = mon_out.hits_seen; got.last = mon_out.last;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %p", $time, got);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_lru_page_buffer_directory_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the LRU page buffer directory: drives request items with
// random idling and stalls, and reports the checker's verdict.
// Depends on lpbd_pkg, lpbd_if, lpbd_checker and the block itself.
module tb_lru_page_buffer_directory_unit;
  import lpbd_pkg::*;

  localparam int FRAMES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_results;
  int   send_idle_pct, recv_idle_pct;
  bit   hold_off;            // long receiver stall in progress
  logic [PGW-1:0] page_pool[16];

  lpbd_in_if  req_ch();
  lpbd_out_if res_ch();

  always #2 clk = ~clk;

  lru_page_buffer_directory_unit #(.FRAMES(FRAMES)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(res_ch.source)
  );

  lpbd_checker #(.FRAMES(FRAMES)) u_checker (
    .clk(clk), .rst_n(rst_n), .mon_in(req_ch.sink), .mon_out(res_ch.sink),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  // receiver: random stalls, plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) res_ch.ready <= 1'b0;
    else res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one item and wait for its handshake; random idle cycles first.
  // valid stays high after the handshake until the next call replaces or drops it.
  task automatic send_request(cmd_t cmd, logic [PGW-1:0] pg, logic wr, logic [FRW-1:0] fs);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.page <= pg;
    req_ch.write_intent <= wr;
    req_ch.frame_sel <= fs;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every predicted result has come.
  task automatic wait_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (200) @(posedge clk);   // extra wait so any unpredicted result item is still caught by the checker
  endtask

  // Mostly fixes over a reused page set so hits, evictions and write-backs occur.
  task automatic random_request();
    int sel;
    logic [PGW-1:0] pg;
    logic wr;
    logic [FRW-1:0] fs;
    sel = $urandom_range(99);
    pg = ($urandom_range(3) == 0) ? PGW'($urandom) : page_pool[4'($urandom_range(15))];
    wr = 1'($urandom_range(1));
    fs = FRW'($urandom);
    if (sel < 55) send_request(CMD_FIX, pg, wr, fs);
    else if (sel < 72) send_request(CMD_UNFIX, pg, wr, fs);
    else if (sel < 82) send_request(CMD_SET_DIRTY, pg, 1'b0, fs);
    else if (sel < 90) send_request(CMD_CLR_DIRTY, pg, 1'b1, fs);
    else if (sel < 96) send_request(CMD_FLUSH, pg, wr, fs);
    else send_request(cmd_t'($urandom_range(7, 5)), pg, wr, fs);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.command = CMD_FIX;
    req_ch.page = '0;
    req_ch.write_intent = 1'b0;
    req_ch.frame_sel = '0;
    for (int i = 0; i < 16; i++) page_pool[i] = PGW'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    send_idle_pct = 6;
    recv_idle_pct = 46;
    hold_off = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-directory corner cases, extremes, every command
    send_request(CMD_UNFIX, '1, 1'b0, '0);          // unfix of unbuffered page
    send_request(CMD_SET_DIRTY, '0, 1'b0, '0);      // dirty on unused frame
    send_request(CMD_FLUSH, '0, 1'b0, '0);          // flush with nothing dirty
    send_request(CMD_FIX, '0, 1'b0, '0);            // read miss: fetch + grant
    send_request(CMD_FIX, '1, 1'b1, '1);            // write miss: grant only
    send_request(CMD_FIX, '0, 1'b1, '0);            // write hit
    send_request(CMD_UNFIX, '0, 1'b0, '0);
    send_request(CMD_UNFIX, '0, 1'b0, '0);
    send_request(CMD_UNFIX, '0, 1'b0, '0);          // pin already zero
    send_request(CMD_CLR_DIRTY, '0, 1'b0, 6'd1);
    send_request(CMD_SET_DIRTY, '0, 1'b0, 6'd0);
    send_request(CMD_SET_DIRTY, '0, 1'b0, '1);      // frame past the used ones
    send_request(CMD_FLUSH, '0, 1'b0, '0);          // flush with one dirty frame
    send_request(cmd_t'(5), '0, 1'b0, '0);
    send_request(cmd_t'(7), '1, 1'b1, '1);
    // fill every frame, then miss again to force evictions (some dirty)
    for (int i = 0; i < FRAMES + 6; i++)
      send_request(CMD_FIX, PGW'(32'h100 + i), (i % 3 == 0), '0);
    send_request(CMD_FLUSH, '0, 1'b0, '0);

    for (int n = 0; n < 34; n++) begin
      if (n == 11) begin
        send_idle_pct = 46;
        recv_idle_pct = 6;
      end
      if (n == 22) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 17) begin
        // sender pauses until every expected result has come
        wait_results();
      end
      if (n == 25) begin
        // long receiver stall while items keep coming
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      random_request();
    end
    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
